// ===== hw/rtl/partial_sum_accumulate_writeback_macros.svh =====
// Assertion macros used by the controller of the accumulate and write-back RTL.
`ifndef PARTIAL_SUM_ACCUMULATE_WRITEBACK_MACROS_SVH
`define PARTIAL_SUM_ACCUMULATE_WRITEBACK_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PSAW_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PSAW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/psaw_pkg.sv =====
// Package with sizes, widths and control types of the accumulate and write-back block.
package psaw_pkg;

  localparam int LANES     = 4;
  localparam int VEC_ELEMS = 16;
  localparam int PASSES    = 2;
  localparam int TILES     = 64;

  localparam int DATA_W  = 32;
  localparam int VIDX_W  = 8;
  localparam int EIDX_W  = 4;
  localparam int SHIFT_W = 5;

  localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int PASS_W = (PASSES > 1) ? $clog2(PASSES) : 1;
  localparam int POS_W  = $clog2(VEC_ELEMS);
  localparam int TILE_W = (TILES > 1) ? $clog2(TILES) : 1;

  localparam int ACC_DEPTH = LANES * VEC_ELEMS;
  localparam int ADDR_W    = $clog2(ACC_DEPTH);
  localparam int VFULL_W   = $clog2(TILES * LANES + 1);

  typedef struct packed {
    logic load_sample;
    logic acc_write;
    logic sel_elem;
    logic out_load;
    logic elem_step;
    logic advance;
  } psaw_cmd_t;

  typedef struct packed {
    logic emit_now;
    logic elem_last;
    logic out_free;
  } psaw_sts_t;

endpackage

// ===== hw/rtl/psaw_if.sv =====
// Valid/ready stream interfaces for input samples and output vector elements.
interface psaw_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [psaw_pkg::DATA_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface psaw_out_if;
  logic                               valid;
  logic                               ready;
  logic        [psaw_pkg::VIDX_W-1:0] vector_index;
  logic        [psaw_pkg::EIDX_W-1:0] element_index;
  logic signed [psaw_pkg::DATA_W-1:0] element_value;
  logic                               last;

  modport source (output valid, output vector_index, output element_index,
                  output element_value, output last, input ready);
  modport sink (input valid, input vector_index, input element_index,
                input element_value, input last, output ready);
endinterface

// ===== hw/rtl/psaw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module psaw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/psaw_ctrl.sv =====
// Controller state machine sequencing accumulation and vector write-back.
`include "partial_sum_accumulate_writeback_macros.svh"

module psaw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  psaw_pkg::psaw_sts_t sts,
  output psaw_pkg::psaw_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready        = 1'b1;
        cmd.load_sample = in_valid;
        if (in_valid) begin
          state_next = sts.emit_now ? ST_EMIT_RD : ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.acc_write = 1'b1;
        cmd.advance   = 1'b1;
        state_next    = ST_IDLE;
      end
      ST_EMIT_RD: begin
        cmd.sel_elem = 1'b1;
        state_next   = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        cmd.sel_elem = 1'b1;
        if (sts.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.elem_step = 1'b1;
          cmd.advance   = sts.elem_last;
          state_next    = sts.elem_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `PSAW_ASSERT_NEXT(a_acc_follows_beat, in_valid && in_ready && !sts.emit_now, cmd.acc_write, "accumulate write did not follow an accumulating beat")
  `PSAW_ASSERT_SAME(a_load_when_free, cmd.out_load, sts.out_free, "result loaded while the output register was occupied")
  `PSAW_ASSERT_SAME(a_advance_point, cmd.advance, cmd.acc_write || (cmd.out_load && sts.elem_last), "counters advanced outside the end of an item")
  `PSAW_ASSERT_NEXT(a_emit_start, in_valid && in_ready && sts.emit_now, state == ST_EMIT_RD && !in_ready, "write-back did not start after an emitting beat")

endmodule

// ===== hw/rtl/psaw_datapath.sv =====
// Datapath with loop counters, accumulator store, shift and output register.
module psaw_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [psaw_pkg::SHIFT_W-1:0]       cfg_wdata,
  input  logic signed [psaw_pkg::DATA_W-1:0] sample,
  input  psaw_pkg::psaw_cmd_t                cmd,
  output psaw_pkg::psaw_sts_t                sts,
  psaw_out_if.source                         results
);

  logic [psaw_pkg::SHIFT_W-1:0] shift_amount;
  logic [psaw_pkg::LANE_W-1:0]  lane_count;
  logic [psaw_pkg::PASS_W-1:0]  pass_count;
  logic [psaw_pkg::POS_W-1:0]   position_count;
  logic [psaw_pkg::TILE_W-1:0]  tile_count;
  logic [psaw_pkg::POS_W-1:0]   elem_count;
  logic [psaw_pkg::DATA_W-1:0]  sample_q;

  logic [psaw_pkg::ACC_DEPTH-1:0] acc_valid;
  logic                           rd_valid;
  logic [psaw_pkg::ADDR_W-1:0]    addr;
  logic [psaw_pkg::POS_W-1:0]     idx;
  logic [psaw_pkg::DATA_W-1:0]    rdata;
  logic [psaw_pkg::DATA_W-1:0]    stored;
  logic [psaw_pkg::DATA_W-1:0]    acc_sum;
  logic [psaw_pkg::DATA_W-1:0]    emit_sum;
  logic [psaw_pkg::VFULL_W-1:0]   vidx_full;
  logic                           elem_last;
  logic                           out_valid;

  assign idx       = cmd.sel_elem ? elem_count : position_count;
  assign addr      = psaw_pkg::ADDR_W'(lane_count) * psaw_pkg::ADDR_W'(psaw_pkg::VEC_ELEMS)
                   + psaw_pkg::ADDR_W'(idx);
  assign stored    = rd_valid ? rdata : '0;
  assign acc_sum   = stored + sample_q;
  assign elem_last = (elem_count == psaw_pkg::POS_W'(psaw_pkg::VEC_ELEMS - 1));
  assign emit_sum  = elem_last ? acc_sum : stored;
  assign vidx_full = psaw_pkg::VFULL_W'(tile_count) * psaw_pkg::VFULL_W'(psaw_pkg::LANES)
                   + psaw_pkg::VFULL_W'(lane_count);

  assign sts.emit_now  = (position_count == psaw_pkg::POS_W'(psaw_pkg::VEC_ELEMS - 1))
                      && (pass_count == psaw_pkg::PASS_W'(psaw_pkg::PASSES - 1));
  assign sts.elem_last = elem_last;
  assign sts.out_free  = !out_valid || results.ready;

  assign results.valid = out_valid;

  psaw_ram #(
    .WIDTH (psaw_pkg::DATA_W),
    .DEPTH (psaw_pkg::ACC_DEPTH)
  ) u_acc_ram (
    .clk   (clk),
    .we    (cmd.acc_write),
    .waddr (addr),
    .wdata (acc_sum),
    .raddr (addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_amount <= '0;
    end else if (cfg_we) begin
      shift_amount <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      sample_q <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      rd_valid <= acc_valid[addr];
      if (cmd.acc_write) begin
        acc_valid[addr] <= 1'b1;
      end else if (cmd.out_load) begin
        acc_valid[addr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elem_count <= '0;
    end else if (cmd.elem_step) begin
      elem_count <= elem_last ? '0 : elem_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_count     <= '0;
      pass_count     <= '0;
      position_count <= '0;
      tile_count     <= '0;
    end else if (cmd.advance) begin
      if (lane_count != psaw_pkg::LANE_W'(psaw_pkg::LANES - 1)) begin
        lane_count <= lane_count + 1'b1;
      end else begin
        lane_count <= '0;
        if (pass_count != psaw_pkg::PASS_W'(psaw_pkg::PASSES - 1)) begin
          pass_count <= pass_count + 1'b1;
        end else begin
          pass_count <= '0;
          if (position_count != psaw_pkg::POS_W'(psaw_pkg::VEC_ELEMS - 1)) begin
            position_count <= position_count + 1'b1;
          end else begin
            position_count <= '0;
            if (tile_count != psaw_pkg::TILE_W'(psaw_pkg::TILES - 1)) begin
              tile_count <= tile_count + 1'b1;
            end else begin
              tile_count <= '0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      results.vector_index  <= psaw_pkg::VIDX_W'(vidx_full);
      results.element_index <= psaw_pkg::EIDX_W'(elem_count);
      results.element_value <= $signed(emit_sum) >>> shift_amount;
      results.last          <= elem_last;
    end
  end

endmodule

// ===== hw/rtl/partial_sum_accumulate_writeback.sv =====
// Top level: accumulates signed partial sums per lane and position and writes back vectors.
// An accumulating beat reads the accumulator RAM, then adds and writes back; the block
// takes no new sample meanwhile. A write-back beat reads the lane's VEC_ELEMS entries one
// at a time through the RAM's registered read port, each in a read state then an output state.
// The first element is registered after its read state; output stalls stretch the write-back.
// Synchronous reset clears the counters, shift amount and per-entry valid bits.
module partial_sum_accumulate_writeback (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [psaw_pkg::SHIFT_W-1:0] cfg_wdata,
  psaw_in_if.sink                      samples,
  psaw_out_if.source                   results
);

  psaw_pkg::psaw_cmd_t cmd;
  psaw_pkg::psaw_sts_t sts;

  psaw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  psaw_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sample    (samples.sample),
    .cmd       (cmd),
    .sts       (sts),
    .results   (results)
  );

endmodule
